@@ rtl/vt4_pkg.sv @@
// Shared types and constants for the 4x4 vertex transform.
package vt4_pkg;

  typedef logic signed [31:0] fx_t;

  typedef struct packed {
    logic        opcode;
    logic signed [31:0] x_in;
    logic signed [31:0] y_in;
    logic signed [31:0] z_in;
    logic signed [31:0] w_in;
  } in_t;

  typedef struct packed {
    logic signed [31:0] x_out;
    logic signed [31:0] y_out;
    logic signed [31:0] z_out;
    logic signed [31:0] w_out;
    logic        divided;
    logic        saturated;
  } out_t;

  typedef struct packed {
    logic          opcode;
    logic          saturated;
    logic [3:0][31:0] r;
  } mac_out_t;

  typedef logic [3:0][3:0][31:0] coef_mat_t;

  localparam int CFG_IDX_W = 4;
  localparam logic [CFG_IDX_W-1:0] CFG_COUNT = 4'd8;
  localparam logic [31:0] FX_MAX = 32'h7fffffff;
  localparam logic [31:0] FX_MIN = 32'h80000000;

endpackage

@@ rtl/vt4_mac.sv @@
// Matrix multiply pipeline: products, adder tree, scale and clamp.
module vt4_mac #(
  parameter int FRAC_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 in_valid,
  input  vt4_pkg::in_t         in_data,
  input  vt4_pkg::coef_mat_t   coef,
  output logic                 out_valid,
  output vt4_pkg::mac_out_t    out_data
);

  localparam logic signed [65:0] MAXW = 66'sd2147483647;
  localparam logic signed [65:0] MINW = -66'sd2147483648;

  logic [4:0] v_r;
  logic op1_r, op2_r, op3_r, op4_r;
  vt4_pkg::fx_t vec1_r [4];
  logic signed [63:0] prod_r [4][4];
  logic signed [64:0] pa_r [4];
  logic signed [64:0] pb_r [4];
  logic signed [65:0] sum_r [4];
  vt4_pkg::mac_out_t out_r;
  vt4_pkg::mac_out_t res_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[3:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      op1_r     <= in_data.opcode;
      vec1_r[0] <= in_data.x_in;
      vec1_r[1] <= in_data.y_in;
      vec1_r[2] <= in_data.z_in;
      vec1_r[3] <= in_data.w_in;
      op2_r     <= op1_r;
      op3_r     <= op2_r;
      op4_r     <= op3_r;
      for (int i = 0; i < 4; i++) begin
        for (int j = 0; j < 4; j++) begin
          prod_r[i][j] <= vec1_r[i] * $signed(coef[i][j]);
        end
      end
      for (int j = 0; j < 4; j++) begin
        pa_r[j]  <= 65'(prod_r[0][j]) + 65'(prod_r[1][j]);
        pb_r[j]  <= 65'(prod_r[2][j]) + 65'(prod_r[3][j]);
        sum_r[j] <= 66'(pa_r[j]) + 66'(pb_r[j]);
      end
      out_r <= res_nxt;
    end
  end

  always_comb begin
    logic signed [65:0] sh;
    res_nxt = '0;
    res_nxt.opcode = op4_r;
    for (int j = 0; j < 4; j++) begin
      sh = sum_r[j] >>> FRAC_BITS;
      if (sh > MAXW) begin
        res_nxt.r[j] = vt4_pkg::FX_MAX;
        res_nxt.saturated = 1'b1;
      end else if (sh < MINW) begin
        res_nxt.r[j] = vt4_pkg::FX_MIN;
        res_nxt.saturated = 1'b1;
      end else begin
        res_nxt.r[j] = sh[31:0];
      end
    end
  end

  assign out_valid = v_r[4];
  assign out_data  = out_r;

endmodule

@@ rtl/vt4_div.sv @@
// Perspective divide: one quotient bit per stage over three lanes.
module vt4_div #(
  parameter int FRAC_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 in_valid,
  input  vt4_pkg::mac_out_t    in_data,
  output logic                 out_valid,
  output vt4_pkg::out_t        out_data
);

  localparam int NB = 32 + FRAC_BITS;
  localparam logic [31:0] ONE_FX = 32'(64'd1 << FRAC_BITS);
  localparam logic [NB-1:0] QMAX_POS = NB'(32'h7fffffff);
  localparam logic [NB-1:0] QMAX_NEG = NB'(33'h080000000);

  typedef struct packed {
    logic             do_div;
    logic             saturated;
    logic [2:0]       neg;
    logic [31:0]      dmag;
    logic [2:0][NB-1:0] num;
    logic [2:0][31:0] rem;
    logic [3:0][31:0] r;
  } stg_t;

  stg_t st_r [NB+1];
  logic [NB:0] sv_r;
  logic out_v_r;
  vt4_pkg::out_t out_r;
  stg_t entry_nxt;
  vt4_pkg::out_t res_nxt;

  always_comb begin
    logic [31:0] w;
    logic [31:0] rv;
    logic [31:0] mag;
    w = in_data.r[3];
    entry_nxt = '0;
    entry_nxt.do_div = in_data.opcode && (w != '0) && (w != ONE_FX);
    entry_nxt.saturated = in_data.saturated;
    entry_nxt.dmag = w[31] ? (~w + 32'd1) : w;
    entry_nxt.r = in_data.r;
    for (int j = 0; j < 3; j++) begin
      rv = in_data.r[j];
      mag = rv[31] ? (~rv + 32'd1) : rv;
      entry_nxt.num[j] = {mag, {FRAC_BITS{1'b0}}};
      entry_nxt.neg[j] = rv[31] ^ w[31];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sv_r    <= '0;
      out_v_r <= 1'b0;
    end else if (en) begin
      sv_r    <= {sv_r[NB-1:0], in_valid};
      out_v_r <= sv_r[NB];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st_r[0] <= entry_nxt;
      out_r   <= res_nxt;
    end
  end

  for (genvar k = 1; k <= NB; k++) begin : g_step
    stg_t nx;
    always_comb begin
      logic [32:0] rt;
      nx = st_r[k-1];
      for (int j = 0; j < 3; j++) begin
        rt = {st_r[k-1].rem[j], st_r[k-1].num[j][NB-1]};
        if (rt >= {1'b0, st_r[k-1].dmag}) begin
          rt = rt - {1'b0, st_r[k-1].dmag};
          nx.num[j] = {st_r[k-1].num[j][NB-2:0], 1'b1};
        end else begin
          nx.num[j] = {st_r[k-1].num[j][NB-2:0], 1'b0};
        end
        nx.rem[j] = rt[31:0];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        st_r[k] <= nx;
      end
    end
  end

  always_comb begin
    logic [NB-1:0] q;
    logic [31:0] qv [3];
    logic sat;
    sat = st_r[NB].saturated;
    for (int j = 0; j < 3; j++) begin
      q = st_r[NB].num[j];
      if (st_r[NB].neg[j]) begin
        if (q > QMAX_NEG) begin
          qv[j] = vt4_pkg::FX_MIN;
          sat = sat | st_r[NB].do_div;
        end else begin
          qv[j] = ~q[31:0] + 32'd1;
        end
      end else begin
        if (q > QMAX_POS) begin
          qv[j] = vt4_pkg::FX_MAX;
          sat = sat | st_r[NB].do_div;
        end else begin
          qv[j] = q[31:0];
        end
      end
    end
    if (st_r[NB].do_div) begin
      res_nxt.x_out = qv[0];
      res_nxt.y_out = qv[1];
      res_nxt.z_out = qv[2];
      res_nxt.w_out = ONE_FX;
      res_nxt.divided = 1'b1;
    end else begin
      res_nxt.x_out = st_r[NB].r[0];
      res_nxt.y_out = st_r[NB].r[1];
      res_nxt.z_out = st_r[NB].r[2];
      res_nxt.w_out = st_r[NB].r[3];
      res_nxt.divided = 1'b0;
    end
    res_nxt.saturated = sat;
  end

  assign out_valid = out_v_r;
  assign out_data  = out_r;

endmodule

@@ rtl/vertex_transform_4x4.sv @@
// Throughput: one vertex per cycle unless the output stalls; the divide pipeline takes one quotient bit per stage.
// A stalled output beat freezes the whole pipeline; input ready follows it.
// Reset (synchronous, active low) clears all valid bits and loads the identity matrix.
// Top level: coefficient registers, transform pipeline and divide pipeline.
module vertex_transform_4x4 #(
  parameter int FRAC_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  vt4_pkg::in_t                  in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output vt4_pkg::out_t                 out_data,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [vt4_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [63:0]                   cfg_data
);

  localparam logic [31:0] ONE_FX = 32'(64'd1 << FRAC_BITS);

  vt4_pkg::coef_mat_t coef_r;
  logic en;
  logic mac_valid;
  vt4_pkg::mac_out_t mac_data;

  assign en        = !out_valid || out_ready;
  assign in_ready  = en;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int r = 0; r < 4; r++) begin
        for (int c = 0; c < 4; c++) begin
          coef_r[r][c] <= (r == c) ? ONE_FX : 32'd0;
        end
      end
    end else if (cfg_valid && (cfg_index < vt4_pkg::CFG_COUNT)) begin
      coef_r[cfg_index[2:1]][{cfg_index[0], 1'b0}] <= cfg_data[31:0];
      coef_r[cfg_index[2:1]][{cfg_index[0], 1'b1}] <= cfg_data[63:32];
    end
  end

  vt4_mac #(.FRAC_BITS(FRAC_BITS)) u_mac (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_valid),
    .in_data   (in_data),
    .coef      (coef_r),
    .out_valid (mac_valid),
    .out_data  (mac_data)
  );

  vt4_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (mac_valid),
    .in_data   (mac_data),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

@@ verif/vertex_transform_4x4_test.sv @@
// Self-checking testbench for the 4x4 vertex transform with perspective divide.
module vertex_transform_4x4_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAC = 16;
  localparam int LATENCY = FRAC + 39;
  localparam int CYCLE_LIMIT = 600000;
  localparam int RANDOM_ITEMS = 1250;
  localparam int PHASES = 8;
  localparam int NUM_REGS = 8;
  localparam int IDX_W = vt4_pkg::CFG_IDX_W;
  localparam logic signed [31:0] ONE = 32'sd65536;
  localparam logic signed [31:0] SMAX = 32'sh7fffffff;
  localparam logic signed [31:0] SMIN = 32'sh80000000;
  localparam logic OP_VECTOR = 1'b0;
  localparam logic OP_POINT = 1'b1;

  typedef struct {
    vt4_pkg::in_t  stim;
    bit            typed;
    vt4_pkg::out_t want;
  } vec_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  vt4_pkg::in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  vt4_pkg::out_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [IDX_W-1:0] cfg_index = '0;
  logic [63:0] cfg_data = '0;

  logic signed [31:0] matrix [4][4];
  vt4_pkg::out_t pending_vertices [$];
  int errors = 0;
  int cycles = 0;
  bit hold_request = 1'b0;

  vertex_transform_4x4 #(.FRAC_BITS(FRAC)) uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #2 clk = ~clk;

  function automatic logic signed [63:0] clamp_fx(logic signed [71:0] v, ref bit sat);
    if (v > 72'(SMAX)) begin
      sat = 1'b1;
      return 64'(SMAX);
    end
    if (v < 72'(SMIN)) begin
      sat = 1'b1;
      return 64'(SMIN);
    end
    return v[63:0];
  endfunction

  function automatic vt4_pkg::out_t transform_vertex(vt4_pkg::in_t v);
    logic signed [31:0] comp [4];
    logic signed [71:0] acc;
    logic signed [63:0] res [4];
    logic signed [63:0] num;
    bit sat;
    bit div;
    vt4_pkg::out_t o;
    sat = 1'b0;
    div = 1'b0;
    comp[0] = v.x_in;
    comp[1] = v.y_in;
    comp[2] = v.z_in;
    comp[3] = v.w_in;
    for (int j = 0; j < 4; j++) begin
      acc = '0;
      for (int i = 0; i < 4; i++) acc += $signed(comp[i]) * $signed(matrix[i][j]);
      res[j] = clamp_fx(acc >>> FRAC, sat);
    end
    if (v.opcode == OP_POINT && res[3] != 0 && res[3] != 64'(ONE)) begin
      for (int j = 0; j < 3; j++) begin
        num = res[j] * 64'sd65536;
        res[j] = clamp_fx(72'(num / res[3]), sat);
      end
      res[3] = 64'(ONE);
      div = 1'b1;
    end
    o.x_out = res[0][31:0];
    o.y_out = res[1][31:0];
    o.z_out = res[2][31:0];
    o.w_out = res[3][31:0];
    o.divided = div;
    o.saturated = sat;
    return o;
  endfunction

  task automatic report(string field, logic [31:0] got, logic [31:0] want);
    errors++;
    $display("mismatch %s: got %h want %h at cycle %0d", field, got, want, cycles);
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    vt4_pkg::out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_vertices.size() == 0) begin
        report("unexpected beat", 32'(out_data.divided), 32'h0);
      end else begin
        want = pending_vertices.pop_front();
        if (out_data.x_out !== want.x_out) report("x_out", out_data.x_out, want.x_out);
        if (out_data.y_out !== want.y_out) report("y_out", out_data.y_out, want.y_out);
        if (out_data.z_out !== want.z_out) report("z_out", out_data.z_out, want.z_out);
        if (out_data.w_out !== want.w_out) report("w_out", out_data.w_out, want.w_out);
        if (out_data.divided !== want.divided)
          report("divided", 32'(out_data.divided), 32'(want.divided));
        if (out_data.saturated !== want.saturated)
          report("saturated", 32'(out_data.saturated), 32'(want.saturated));
      end
    end
  end

  initial begin
    int mode;
    int span;
    mode = 0;
    span = 0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (hold_request) begin
        out_ready <= 1'b0;
        repeat (400) @(posedge clk);
        hold_request = 1'b0;
      end
      if (span == 0) begin
        mode = $urandom_range(0, 2);
        span = $urandom_range(8, 80);
      end
      span--;
      case (mode)
        0: out_ready <= 1'b1;
        1: out_ready <= ($urandom_range(0, 1) == 1);
        default: out_ready <= ($urandom_range(0, 4) == 0);
      endcase
    end
  end

  task automatic write_coef(logic [IDX_W-1:0] idx, logic [63:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx < vt4_pkg::CFG_COUNT) begin
      matrix[idx >> 1][(idx & 1) * 2] = value[31:0];
      matrix[idx >> 1][(idx & 1) * 2 + 1] = value[63:32];
    end
  endtask

  task automatic push_vertex(vt4_pkg::in_t v, bit typed, vt4_pkg::out_t want);
    in_valid <= 1'b1;
    in_data <= v;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_vertices.push_back(typed ? want : transform_vertex(v));
  endtask

  int burst_left = 0;

  task automatic pace_sender();
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = $urandom_range(0, 30);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_vertices.size() != 0) @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
  endtask

  function automatic logic signed [31:0] rand_fx(int kind);
    case (kind)
      0: return $urandom;
      1: return $signed($urandom_range(0, 8 << FRAC)) - (4 <<< FRAC);
      2: return ($urandom_range(0, 1) == 1) ? SMAX : SMIN;
      default: return $signed($urandom_range(0, 64)) - 32;
    endcase
  endfunction

  function automatic logic [63:0] rand_coef(int setting);
    logic [31:0] lo;
    logic [31:0] hi;
    case (setting)
      0: return {SMAX, SMAX};
      1: return {SMIN, SMIN};
      2: return 64'h0;
      3: return {$urandom, $urandom};
      default: begin
        lo = rand_fx($urandom_range(1, 3));
        hi = rand_fx($urandom_range(1, 3));
        return {hi, lo};
      end
    endcase
  endfunction

  vec_row_t directed [10];
  vt4_pkg::out_t none;

  initial begin
    vt4_pkg::in_t v;
    int kind;
    for (int r = 0; r < 4; r++)
      for (int c = 0; c < 4; c++) matrix[r][c] = (r == c) ? ONE : 32'sd0;
    none = '0;
    directed[0] = '{'{OP_VECTOR, ONE, 2*ONE, 3*ONE, 4*ONE}, 1'b1,
                    '{ONE, 2*ONE, 3*ONE, 4*ONE, 1'b0, 1'b0}};
    directed[1] = '{'{OP_VECTOR, SMAX, SMIN, SMAX, SMIN}, 1'b1,
                    '{SMAX, SMIN, SMAX, SMIN, 1'b0, 1'b0}};
    directed[2] = '{'{OP_VECTOR, 0, 0, 0, 0}, 1'b1, '{0, 0, 0, 0, 1'b0, 1'b0}};
    directed[3] = '{'{OP_POINT, 2*ONE, 4*ONE, 6*ONE, 2*ONE}, 1'b1,
                    '{ONE, 2*ONE, 3*ONE, ONE, 1'b1, 1'b0}};
    directed[4] = '{'{OP_POINT, 3*ONE, -5*ONE, 7*ONE, ONE}, 1'b1,
                    '{3*ONE, -5*ONE, 7*ONE, ONE, 1'b0, 1'b0}};
    directed[5] = '{'{OP_POINT, 3*ONE, 4*ONE, 5*ONE, 0}, 1'b1,
                    '{3*ONE, 4*ONE, 5*ONE, 0, 1'b0, 1'b0}};
    directed[6] = '{'{OP_POINT, SMAX, SMIN, 0, ONE/2}, 1'b1,
                    '{SMAX, SMIN, 0, ONE, 1'b1, 1'b1}};
    directed[7] = '{'{OP_POINT, ONE, -ONE, 2*ONE, -ONE}, 1'b1,
                    '{-ONE, ONE, -2*ONE, ONE, 1'b1, 1'b0}};
    directed[8] = '{'{OP_POINT, SMIN, 0, 0, SMIN}, 1'b1, '{ONE, 0, 0, ONE, 1'b1, 1'b0}};
    directed[9] = '{'{OP_POINT, 1, -1, 0, 1}, 1'b1, '{ONE, -ONE, 0, ONE, 1'b1, 1'b0}};

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[i]) begin
      push_vertex(directed[i].stim, directed[i].typed, directed[i].want);
      pace_sender();
    end
    drain();

    for (int p = 0; p < PHASES; p++) begin
      for (int r = 0; r < NUM_REGS; r++) write_coef(IDX_W'(r), rand_coef(p));
      write_coef(IDX_W'($urandom_range(NUM_REGS, 15)), {$urandom, $urandom});
      cfg_valid <= 1'b0;
      @(posedge clk);
      if (p == 3) hold_request = 1'b1;
      for (int n = 0; n < RANDOM_ITEMS / PHASES; n++) begin
        kind = $urandom_range(0, 9);
        v.opcode = $urandom_range(0, 1);
        v.x_in = rand_fx(kind < 4 ? 0 : (kind < 8 ? 1 : kind - 6));
        v.y_in = rand_fx(kind < 4 ? 0 : (kind < 8 ? 1 : kind - 6));
        v.z_in = rand_fx(kind < 4 ? 0 : (kind < 8 ? 1 : kind - 6));
        v.w_in = rand_fx(kind < 4 ? 0 : (kind < 8 ? 1 : kind - 6));
        push_vertex(v, 1'b0, none);
        pace_sender();
      end
      drain();
    end

    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
